// File: sv/sha1_pkg.sv
// shared types, constants and round function of the sha-1 engine
package sha1_pkg;

    // request mode codes
    localparam logic [1:0] MODE_ABSORB      = 2'd0;
    localparam logic [1:0] MODE_ABSORB_LAST = 2'd1;
    localparam logic [1:0] MODE_FINISH      = 2'd2;

    // block buffer geometry: sixteen 32-bit words
    localparam int BLOCK_WORDS = 16;
    localparam int WORD_BITS   = 32;
    localparam int ROUNDS      = 80;
    localparam int DIGEST_WORDS = 5;

    // initial chaining values
    localparam logic [31:0] H0_INIT = 32'h67452301;
    localparam logic [31:0] H1_INIT = 32'hEFCDAB89;
    localparam logic [31:0] H2_INIT = 32'h98BADCFE;
    localparam logic [31:0] H3_INIT = 32'h10325476;
    localparam logic [31:0] H4_INIT = 32'hC3D2E1F0;

    // round constants
    localparam logic [31:0] K0 = 32'h5A827999;
    localparam logic [31:0] K1 = 32'h6ED9EBA1;
    localparam logic [31:0] K2 = 32'h8F1BBCDC;
    localparam logic [31:0] K3 = 32'hCA62C1D6;

    localparam logic [7:0] PAD_BYTE = 8'h80;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PAD,
        ST_ZERO,
        ST_LOAD,
        ST_ROUND,
        ST_FINAL
    } sha1_state_t;

    // working variables of one compression
    typedef struct packed {
        logic [31:0] a;
        logic [31:0] b;
        logic [31:0] c;
        logic [31:0] d;
        logic [31:0] e;
    } sha1_work_t;

    function automatic logic [31:0] rotl(input logic [31:0] v, input int n);
        rotl = (v << n) | (v >> (32 - n));
    endfunction

    // one sha-1 round
    function automatic sha1_work_t sha1_round(
        input sha1_work_t  s,
        input logic [31:0] w,
        input logic [6:0]  rnd
    );
        logic [31:0] f;
        logic [31:0] k;
        sha1_work_t  r;
        if (rnd < 7'd20) begin
            f = (s.b & s.c) | (~s.b & s.d);
            k = K0;
        end else if (rnd < 7'd40) begin
            f = s.b ^ s.c ^ s.d;
            k = K1;
        end else if (rnd < 7'd60) begin
            f = (s.b & s.c) | (s.b & s.d) | (s.c & s.d);
            k = K2;
        end else begin
            f = s.b ^ s.c ^ s.d;
            k = K3;
        end
        r.a = rotl(s.a, 5) + f + s.e + w + k;
        r.b = s.a;
        r.c = rotl(s.b, 30);
        r.d = s.c;
        r.e = s.d;
        return r;
    endfunction

endpackage

// File: sv/sha1_hash_engine.sv
// sha-1 engine top level: byte intake, padding sequencer, round datapath, digest output
// The engine takes one message byte per request and packs four bytes into a word of a
// 16 x 32 block ram. The byte that completes a 64-byte block starts a compression (a load
// step that loads the working variables and fetches word 0, 80 rounds at one round per
// cycle, and a final step that updates the chaining words), during which no request is
// taken; the message schedule runs from the ram for rounds 0 to 15 and from a 16-word
// shift window after that. A finishing request writes the padding as whole words and runs
// one compression, or two when 56 or more bytes are pending. The five digest words then
// leave one per cycle while res_ready is high from an output register, and the next
// message may start while they wait to be taken.
module sha1_hash_engine (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        req_valid,
    output logic        req_ready,
    input  logic [1:0]  mode,
    input  logic [7:0]  data_byte,
    output logic        res_valid,
    input  logic        res_ready,
    output logic [31:0] digest_word,
    output logic [2:0]  word_index,
    output logic        last_word
);

    import sha1_pkg::*;

    localparam int AW = $clog2(BLOCK_WORDS);

    // control state
    sha1_state_t state_reg, state_next;
    logic [5:0]  fill_reg, fill_next;
    logic [63:0] len_reg, len_next;
    logic [4:0]  wptr_reg, wptr_next;
    logic [6:0]  rnd_reg, rnd_next;
    logic        finish_reg, finish_next;
    logic        extra_reg, extra_next;
    logic        obusy_reg, obusy_next;
    logic [2:0]  oidx_reg, oidx_next;
    logic [31:0] h_reg [DIGEST_WORDS];
    logic [31:0] h_next [DIGEST_WORDS];

    // payload state
    logic [23:0] word_reg, word_next;
    sha1_work_t  work_reg, work_next;
    logic [31:0] win_reg [BLOCK_WORDS];
    logic [31:0] win_next [BLOCK_WORDS];
    logic [31:0] osh_reg [DIGEST_WORDS];
    logic [31:0] osh_next [DIGEST_WORDS];

    // ram ports
    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    logic [31:0]   ram_wdata;
    logic [AW-1:0] ram_raddr;
    logic [31:0]   ram_rdata;

    logic        req_acc;
    logic        res_acc;
    logic [31:0] w_cur;
    logic [31:0] sum [DIGEST_WORDS];
    logic [31:0] pad_word;

    sha1_ram #(
        .WIDTH (WORD_BITS),
        .DEPTH (BLOCK_WORDS)
    ) u_buf (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign req_ready = (state_reg == ST_IDLE);
    assign req_acc   = req_valid && req_ready;
    assign res_acc   = res_valid && res_ready;

    // message schedule word for the current round
    assign w_cur = (rnd_reg < 7'd16) ? ram_rdata
                 : rotl(win_reg[13] ^ win_reg[8] ^ win_reg[2] ^ win_reg[0], 1);

    // chaining update sums
    assign sum[0] = h_reg[0] + work_reg.a;
    assign sum[1] = h_reg[1] + work_reg.b;
    assign sum[2] = h_reg[2] + work_reg.c;
    assign sum[3] = h_reg[3] + work_reg.d;
    assign sum[4] = h_reg[4] + work_reg.e;

    // pending bytes followed by the 0x80 marker, left aligned
    always_comb
    begin
        unique case (fill_reg[1:0])
            2'd0: pad_word = {PAD_BYTE, 24'd0};
            2'd1: pad_word = {word_reg[7:0], PAD_BYTE, 16'd0};
            2'd2: pad_word = {word_reg[15:0], PAD_BYTE, 8'd0};
            2'd3: pad_word = {word_reg[23:0], PAD_BYTE};
            default: pad_word = {PAD_BYTE, 24'd0};
        endcase
    end

    // output stage
    assign res_valid   = obusy_reg;
    assign digest_word = osh_reg[0];
    assign word_index  = oidx_reg;
    assign last_word   = (oidx_reg == 3'(DIGEST_WORDS - 1));

    // next state and datapath control
    always_comb
    begin
        state_next  = state_reg;
        fill_next   = fill_reg;
        len_next    = len_reg;
        wptr_next   = wptr_reg;
        rnd_next    = rnd_reg;
        finish_next = finish_reg;
        extra_next  = extra_reg;
        obusy_next  = obusy_reg;
        oidx_next   = oidx_reg;
        word_next   = word_reg;
        work_next   = work_reg;
        h_next      = h_reg;
        win_next    = win_reg;
        osh_next    = osh_reg;
        ram_we      = 1'b0;
        ram_waddr   = fill_reg[5:2];
        ram_wdata   = {word_reg, data_byte};
        ram_raddr   = '0;

        // digest words leave one per accepted result transfer
        if (res_acc)
        begin
            for (int i = 0; i < DIGEST_WORDS - 1; i++)
            begin
                osh_next[i] = osh_reg[i + 1];
            end
            osh_next[DIGEST_WORDS - 1] = osh_reg[DIGEST_WORDS - 1];
            oidx_next = oidx_reg + 3'd1;
            if (oidx_reg == 3'(DIGEST_WORDS - 1))
            begin
                obusy_next = 1'b0;
            end
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (req_acc)
                begin
                    if (mode == MODE_ABSORB || mode == MODE_ABSORB_LAST)
                    begin
                        // pack the byte, write a word when four are in
                        word_next = {word_reg[15:0], data_byte};
                        ram_we    = (fill_reg[1:0] == 2'd3);
                        fill_next = fill_reg + 6'd1;
                        len_next  = len_reg + 64'd8;
                        if (fill_reg == 6'd63)
                        begin
                            // a last byte that fills the block leaves all padding for a
                            // fresh block
                            finish_next = (mode == MODE_ABSORB_LAST);
                            extra_next  = (mode == MODE_ABSORB_LAST);
                            state_next  = ST_LOAD;
                        end
                        else if (mode == MODE_ABSORB_LAST)
                        begin
                            finish_next = 1'b1;
                            state_next  = ST_PAD;
                        end
                    end
                    else if (mode == MODE_FINISH)
                    begin
                        finish_next = 1'b1;
                        state_next  = ST_PAD;
                    end
                end
            end

            ST_PAD:
            begin
                // word holding the marker byte
                ram_we     = 1'b1;
                ram_waddr  = fill_reg[5:2];
                ram_wdata  = pad_word;
                extra_next = (fill_reg >= 6'd56);
                wptr_next  = {1'b0, fill_reg[5:2]} + 5'd1;
                state_next = ST_ZERO;
            end

            ST_ZERO:
            begin
                // zero words, then the bit length in the last two words of the final block
                if (extra_reg && wptr_reg == 5'(BLOCK_WORDS))
                begin
                    state_next = ST_LOAD;
                end
                else
                begin
                    ram_we    = 1'b1;
                    ram_waddr = wptr_reg[AW-1:0];
                    if (!extra_reg && wptr_reg == 5'(BLOCK_WORDS - 2))
                    begin
                        ram_wdata = len_reg[63:32];
                    end
                    else if (!extra_reg && wptr_reg == 5'(BLOCK_WORDS - 1))
                    begin
                        ram_wdata = len_reg[31:0];
                    end
                    else
                    begin
                        ram_wdata = '0;
                    end
                    wptr_next = wptr_reg + 5'd1;
                    if (!extra_reg && wptr_reg == 5'(BLOCK_WORDS - 1))
                    begin
                        state_next = ST_LOAD;
                    end
                end
            end

            ST_LOAD:
            begin
                // fetch word 0 and load the working variables
                ram_raddr   = '0;
                work_next.a = h_reg[0];
                work_next.b = h_reg[1];
                work_next.c = h_reg[2];
                work_next.d = h_reg[3];
                work_next.e = h_reg[4];
                rnd_next    = '0;
                state_next  = ST_ROUND;
            end

            ST_ROUND:
            begin
                // one round per cycle, prefetch the next block word
                ram_raddr = rnd_reg[AW-1:0] + AW'(1);
                work_next = sha1_round(work_reg, w_cur, rnd_reg);
                for (int i = 0; i < BLOCK_WORDS - 1; i++)
                begin
                    win_next[i] = win_reg[i + 1];
                end
                win_next[BLOCK_WORDS - 1] = w_cur;
                rnd_next = rnd_reg + 7'd1;
                if (rnd_reg == 7'(ROUNDS - 1))
                begin
                    state_next = ST_FINAL;
                end
            end

            ST_FINAL:
            begin
                priority if (!finish_reg)
                begin
                    h_next     = sum;
                    state_next = ST_IDLE;
                end
                else if (extra_reg)
                begin
                    // second padding block follows
                    h_next     = sum;
                    extra_next = 1'b0;
                    wptr_next  = '0;
                    if (fill_reg == 6'd0)
                    begin
                        // full data block: marker still to be written at word 0
                        state_next = ST_PAD;
                    end
                    else
                    begin
                        state_next = ST_ZERO;
                    end
                end
                else if (!obusy_reg || (res_acc && oidx_reg == 3'(DIGEST_WORDS - 1)))
                begin
                    // hand the digest to the output and restart the message
                    osh_next    = sum;
                    obusy_next  = 1'b1;
                    oidx_next   = '0;
                    h_next[0]   = H0_INIT;
                    h_next[1]   = H1_INIT;
                    h_next[2]   = H2_INIT;
                    h_next[3]   = H3_INIT;
                    h_next[4]   = H4_INIT;
                    len_next    = '0;
                    fill_next   = '0;
                    finish_next = 1'b0;
                    state_next  = ST_IDLE;
                end
                else
                begin
                    // previous digest still in the output register
                    state_next = ST_FINAL;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            fill_reg   <= '0;
            len_reg    <= '0;
            wptr_reg   <= '0;
            rnd_reg    <= '0;
            finish_reg <= 1'b0;
            extra_reg  <= 1'b0;
            obusy_reg  <= 1'b0;
            oidx_reg   <= '0;
            h_reg[0]   <= H0_INIT;
            h_reg[1]   <= H1_INIT;
            h_reg[2]   <= H2_INIT;
            h_reg[3]   <= H3_INIT;
            h_reg[4]   <= H4_INIT;
        end
        else
        begin
            state_reg  <= state_next;
            fill_reg   <= fill_next;
            len_reg    <= len_next;
            wptr_reg   <= wptr_next;
            rnd_reg    <= rnd_next;
            finish_reg <= finish_next;
            extra_reg  <= extra_next;
            obusy_reg  <= obusy_next;
            oidx_reg   <= oidx_next;
            h_reg      <= h_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        word_reg <= word_next;
        work_reg <= work_next;
        win_reg  <= win_next;
        osh_reg  <= osh_next;
    end

endmodule

// File: sv/sha1_ram.sv
// generic single-port-write ram with registered read
module sha1_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
